>>> src/tmw_pkg.sv
// Shared constants of the trimmed mean window filter.
`default_nettype none
package tmw_pkg;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 6;
	localparam int WINDOW_SIZE_W = 6;
	localparam int TRIM_COUNT_W  = 4;
	localparam int KEPT_W        = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIM_COUNT  = 1'd1;

	localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RST = 6'd20;
	localparam logic [TRIM_COUNT_W-1:0]  TRIM_COUNT_RST  = 4'd2;
endpackage
`default_nettype wire

>>> src/tmw_if.sv
// Handshake interfaces for the sample and mean channels.
`default_nettype none
interface tmw_sample_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tmw_mean_if #(parameter int W = 16);
	logic                      valid;
	logic                      ready;
	logic [W-1:0]              mean;
	logic [tmw_pkg::KEPT_W-1:0] kept_count;

	modport source (output valid, output mean, output kept_count, input ready);
	modport sink (input valid, input mean, input kept_count, output ready);
endinterface
`default_nettype wire

>>> src/trimmed_mean_window.sv
// Trimmed mean window filter: collects window_size signed samples, keeps them in
// ascending order as they arrive, and on the last sample of a window drops trim_count
// samples from each end (fewer if that would leave none), sums the rest and divides by
// the number kept (truncated toward zero). One sorted RAM with one read and one write
// port and a small sequencer do all the work. Each sample is inserted by a shift-down
// pass over the RAM, one entry per cycle, that stops at the first entry not above the
// new sample, so the pass is short when samples arrive nearly in order. The item that
// completes a window also pays for a scan of the RAM, a restoring division and the load
// of the output register. Ready is high only while the sequencer is idle; a finished
// mean waits in an output register so the next sample is taken while it is unclaimed.
// Each RAM entry carries its arrival position, so a window that was shortened while
// filling averages only its first window_size samples. No clearing pass is needed after
// reset: only entries written in the current window are read.
`default_nettype none
module trimmed_mean_window #(
	parameter int MAX_SAMPLES  = 32,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [tmw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [tmw_pkg::CFG_DATA_W-1:0]  cfg_data,
	tmw_sample_if.sink                     samples,
	tmw_mean_if.source                     means
);
	localparam int SW    = SAMPLE_WIDTH;
	localparam int IDXW  = $clog2(MAX_SAMPLES);          // RAM address / arrival tag
	localparam int CNTW  = $clog2(MAX_SAMPLES + 1);      // fill count, holds MAX_SAMPLES
	localparam int WW    = (CNTW > tmw_pkg::WINDOW_SIZE_W) ? CNTW : tmw_pkg::WINDOW_SIZE_W;
	localparam int EW    = SW + IDXW;                     // entry: {value, tag}
	localparam int SUMW  = SW + tmw_pkg::KEPT_W;          // at most 63 samples summed
	localparam int STEPW = $clog2(SUMW);
	localparam int KW    = tmw_pkg::KEPT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_PUT  = 3'd2;
	localparam logic [2:0] ST_SUM  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	// configuration
	logic [tmw_pkg::WINDOW_SIZE_W-1:0] window_size_q;
	logic [tmw_pkg::TRIM_COUNT_W-1:0]  trim_count_q;

	// sequencer
	logic [2:0]       state_q;
	logic [CNTW-1:0]  fill_q;
	logic             complete_q;
	logic [EW-1:0]    key_q;
	logic [IDXW-1:0]  pos_q;
	logic [IDXW-1:0]  put_q;
	logic [CNTW-1:0]  scan_q;
	logic             rd_vld_s1;
	logic [WW-1:0]    rank_q;
	logic signed [SUMW-1:0] sum_q;
	logic             neg_q;
	logic [SUMW-1:0]  dq_q;
	logic [KW-1:0]    rem_q;
	logic [STEPW-1:0] step_q;

	// output register
	logic             out_vld_q;
	logic [SW-1:0]    mean_q;
	logic [KW-1:0]    kept_q;

	// sorted sample RAM
	logic [EW-1:0]    sample_store [MAX_SAMPLES];
	logic [EW-1:0]    rd_q;
	logic             mem_we;
	logic [IDXW-1:0]  mem_waddr;
	logic [EW-1:0]    mem_wdata;
	logic [IDXW-1:0]  mem_raddr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_store[mem_waddr] <= mem_wdata;
		end
		rd_q <= sample_store[mem_raddr];
	end

	logic signed [SW-1:0] rd_val;
	logic signed [SW-1:0] key_val;
	logic [IDXW-1:0]      rd_tag;
	assign rd_val  = $signed(rd_q[EW-1 -: SW]);
	assign rd_tag  = rd_q[IDXW-1:0];
	assign key_val = $signed(key_q[EW-1 -: SW]);

	// effective window and trim; user keeps config stable while busy, unchecked
	logic [WW-1:0] win;
	logic [WW-1:0] win_raw;
	logic [WW-1:0] trim_raw;
	logic [WW-1:0] trim_eff;
	logic [WW-1:0] hi_rank;
	logic [WW-1:0] kept_w;
	logic [KW-1:0] kept;

	always_comb begin
		win_raw = WW'(window_size_q);
		if (window_size_q == '0) begin
			win_raw = WW'(1);
		end
		win = (win_raw > WW'(MAX_SAMPLES)) ? WW'(MAX_SAMPLES) : win_raw;
		trim_raw = WW'(trim_count_q);
		trim_eff = ((trim_raw << 1) >= win) ? ((win - WW'(1)) >> 1) : trim_raw;
		hi_rank  = win - trim_eff;
		kept_w   = win - (trim_eff << 1);
		kept     = kept_w[KW-1:0];
	end

	logic [CNTW-1:0] fill_next;
	logic            in_fire;
	logic            out_free;
	assign fill_next = (fill_q < CNTW'(MAX_SAMPLES)) ? fill_q + CNTW'(1) : fill_q;
	assign in_fire   = samples.valid && samples.ready;
	assign out_free  = !out_vld_q || means.ready;

	// restoring division step
	logic [KW:0]   div_trial;
	logic          div_ge;
	logic [KW:0]   div_diff;
	assign div_trial = {rem_q, dq_q[SUMW-1]};
	assign div_ge    = div_trial >= {1'b0, kept};
	assign div_diff  = div_trial - {1'b0, kept};

	logic in_window;
	assign in_window = WW'(rd_tag) < win;

	// RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = put_q;
		mem_wdata = key_q;
		mem_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				mem_raddr = IDXW'(fill_q - CNTW'(1));
			end
			ST_INS: begin
				mem_raddr = pos_q - IDXW'(1);
				if (rd_val > key_val) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q + IDXW'(1);
					mem_wdata = rd_q;
				end
			end
			ST_PUT: begin
				mem_we = 1'b1;
			end
			ST_SUM: begin
				mem_raddr = scan_q[IDXW-1:0];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= tmw_pkg::WINDOW_SIZE_RST;
			trim_count_q  <= tmw_pkg::TRIM_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tmw_pkg::REG_WINDOW_SIZE: window_size_q <= cfg_data[tmw_pkg::WINDOW_SIZE_W-1:0];
				tmw_pkg::REG_TRIM_COUNT:  trim_count_q  <= cfg_data[tmw_pkg::TRIM_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			complete_q <= 1'b0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (means.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						fill_q     <= fill_next;
						complete_q <= WW'(fill_next) >= win;
						rd_vld_s1  <= 1'b0;
						if (fill_q == CNTW'(MAX_SAMPLES)) begin
							// store full: sample only closes the window
							state_q <= ST_SUM;
						end else if (fill_q == '0) begin
							state_q <= ST_PUT;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					if (!(rd_val > key_val) || pos_q == '0) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					state_q <= complete_q ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					rd_vld_s1 <= scan_q < fill_q;
					if (scan_q == fill_q && !rd_vld_s1) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == STEPW'(SUMW - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q  <= {samples.sample, IDXW'(fill_q)};
				pos_q  <= IDXW'(fill_q - CNTW'(1));
				put_q  <= '0;
				scan_q <= '0;
				rank_q <= '0;
				sum_q  <= '0;
			end
			ST_INS: begin
				if (rd_val > key_val) begin
					pos_q <= pos_q - IDXW'(1);
					put_q <= '0;
				end else begin
					put_q <= pos_q + IDXW'(1);
				end
			end
			ST_SUM: begin
				if (scan_q < fill_q) begin
					scan_q <= scan_q + CNTW'(1);
				end
				// only the first win arrivals count; keep ranks trim .. win-trim-1
				if (rd_vld_s1 && in_window) begin
					rank_q <= rank_q + WW'(1);
					if (rank_q >= trim_eff && rank_q < hi_rank) begin
						sum_q <= sum_q + SUMW'(rd_val);
					end
				end
				neg_q  <= sum_q[SUMW-1];
				dq_q   <= sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				rem_q  <= div_ge ? div_diff[KW-1:0] : div_trial[KW-1:0];
				dq_q   <= {dq_q[SUMW-2:0], div_ge};
				step_q <= step_q + STEPW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					mean_q <= neg_q ? SW'(-dq_q) : dq_q[SW-1:0];
					kept_q <= kept;
				end
			end
			default: ;
		endcase
	end

	assign samples.ready    = (state_q == ST_IDLE);
	assign means.valid      = out_vld_q;
	assign means.mean       = mean_q;
	assign means.kept_count = kept_q;
endmodule
`default_nettype wire
